// ===== sv/tea_pkg.sv =====
// Shared types and constants for the TEA block cipher.
package tea_pkg;

  // Key schedule constant.
  localparam logic [31:0] DELTA = 32'h9e37_79b9;

  // Configuration port geometry and register indexes.
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned IDX_W  = 3;
  localparam logic [IDX_W-1:0] REG_KEY0 = 3'd0;
  localparam logic [IDX_W-1:0] REG_KEY1 = 3'd1;
  localparam logic [IDX_W-1:0] REG_KEY2 = 3'd2;
  localparam logic [IDX_W-1:0] REG_KEY3 = 3'd3;
  localparam logic [IDX_W-1:0] REG_MODE = 3'd4;

  typedef struct packed {
    logic [31:0] v0;
    logic [31:0] v1;
    logic        last;
  } tea_data_t;

  typedef struct packed {
    logic [31:0] k0;
    logic [31:0] k1;
    logic [31:0] k2;
    logic [31:0] k3;
  } tea_key_t;

  // Per-stage control: running sum, which half is updated and the direction.
  typedef struct packed {
    logic [31:0] sum;
    logic        update_v0;
    logic        subtract;
  } tea_ctl_t;

endpackage

// ===== sv/tea_in_if.sv =====
// Input channel: one plaintext or ciphertext block per transfer.
interface tea_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] first_word;
  logic [31:0] second_word;
  logic        last_block;

  modport source (output valid, first_word, second_word, last_block, input ready);
  modport sink (input valid, first_word, second_word, last_block, output ready);
endinterface

// ===== sv/tea_out_if.sv =====
// Output channel: one transformed block per transfer.
interface tea_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_first_word;
  logic [31:0] result_second_word;
  logic        result_last;

  modport source (output valid, result_first_word, result_second_word, result_last,
                  input ready);
  modport sink (input valid, result_first_word, result_second_word, result_last,
                output ready);
endinterface

// ===== sv/tea_cfg.sv =====
// APB-style register file holding the key words and the mode bit.
module tea_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tea_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output tea_pkg::tea_key_t          key,
  output logic                       decrypt_mode
);

  logic [tea_pkg::IDX_W-1:0] idx;
  logic                      wr;

  assign idx    = paddr[tea_pkg::ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      key          <= '0;
      decrypt_mode <= 1'b0;
    end else if (wr) begin
      case (idx)
        tea_pkg::REG_KEY0: key.k0 <= pwdata;
        tea_pkg::REG_KEY1: key.k1 <= pwdata;
        tea_pkg::REG_KEY2: key.k2 <= pwdata;
        tea_pkg::REG_KEY3: key.k3 <= pwdata;
        tea_pkg::REG_MODE: decrypt_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      tea_pkg::REG_KEY0: prdata = key.k0;
      tea_pkg::REG_KEY1: prdata = key.k1;
      tea_pkg::REG_KEY2: prdata = key.k2;
      tea_pkg::REG_KEY3: prdata = key.k3;
      tea_pkg::REG_MODE: prdata = {31'd0, decrypt_mode};
      default:           prdata = '0;
    endcase
  end

endmodule

// ===== sv/tea_round_stage.sv =====
// One registered half round of TEA with its own valid bit and handshake.
module tea_round_stage (
  input  logic               clk,
  input  logic               rst,
  input  tea_pkg::tea_key_t  key,
  input  tea_pkg::tea_ctl_t  ctl,
  input  logic               in_valid,
  output logic               in_ready,
  input  tea_pkg::tea_data_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tea_pkg::tea_data_t out_data
);

  logic [31:0]        x;
  logic [31:0]        y;
  logic [31:0]        ka;
  logic [31:0]        kb;
  logic [31:0]        mix;
  logic [31:0]        y_new;
  tea_pkg::tea_data_t data_next;

  // The half that changes is mixed from the other half.
  always_comb begin
    if (ctl.update_v0) begin
      x  = in_data.v1;
      y  = in_data.v0;
      ka = key.k0;
      kb = key.k1;
    end else begin
      x  = in_data.v0;
      y  = in_data.v1;
      ka = key.k2;
      kb = key.k3;
    end
    mix   = ((x << 4) + ka) ^ (x + ctl.sum) ^ ((x >> 5) + kb);
    y_new = ctl.subtract ? (y - mix) : (y + mix);
    data_next      = in_data;
    if (ctl.update_v0) begin
      data_next.v0 = y_new;
    end else begin
      data_next.v1 = y_new;
    end
  end

  // A stage takes a new block when it is empty or its content moves on.
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== sv/tea_block_cipher.sv =====
// Top level of the pipelined TEA block cipher.
//
// Blocks arrive on the blk channel as two 32-bit words and a last-block flag,
// and leave on the res channel with the flag copied through. Each block is
// encrypted or decrypted with TEA under the 128-bit key held in the register
// file (key words at byte addresses 0, 4, 8 and 12, mode bit at 16, where
// 1 selects decryption). The user must write the registers over the APB-style
// port only while no block is in flight; the block itself does not enforce this.
//
// Every round is split into two half rounds, and each half round is one
// register stage between blk and res. A new block can be taken in every
// cycle while the receiver keeps taking results.
//
// Reset clears all stage valid bits and all register-file registers to zero (encrypt mode,
// all-zero key). When the receiver stalls, blocks pile up stage by stage;
// blk stays ready while any stage further on is empty, and nothing is lost
// or repeated.
module tea_block_cipher #(
  parameter int unsigned ROUNDS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  tea_in_if.sink                     blk,
  tea_out_if.source                  res,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tea_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int unsigned STAGES = 2 * ROUNDS;

  tea_pkg::tea_key_t  key;
  logic               decrypt_mode;
  tea_pkg::tea_data_t data  [0:STAGES];
  logic               valid [0:STAGES];
  logic               ready [0:STAGES];
  tea_pkg::tea_ctl_t  ctl   [0:STAGES-1];

  tea_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .key          (key),
    .decrypt_mode (decrypt_mode)
  );

  assign data[0].v0   = blk.first_word;
  assign data[0].v1   = blk.second_word;
  assign data[0].last = blk.last_block;
  assign valid[0]     = blk.valid;
  assign blk.ready    = ready[0];

  assign res.valid              = valid[STAGES];
  assign res.result_first_word  = data[STAGES].v0;
  assign res.result_second_word = data[STAGES].v1;
  assign res.result_last        = data[STAGES].last;
  assign ready[STAGES]          = res.ready;

  for (genvar j = 0; j < STAGES; j++) begin : g_stage
    // Running sum of this round: delta*(r+1) forwards, delta*(ROUNDS-r) backwards.
    localparam logic [63:0] ENC_PROD = 64'(tea_pkg::DELTA) * 64'(j / 2 + 1);
    localparam logic [63:0] DEC_PROD = 64'(tea_pkg::DELTA) * 64'(ROUNDS - j / 2);
    localparam logic        FIRST_HALF = ((j % 2) == 0);

    assign ctl[j].sum       = decrypt_mode ? DEC_PROD[31:0] : ENC_PROD[31:0];
    assign ctl[j].update_v0 = FIRST_HALF ^ decrypt_mode;
    assign ctl[j].subtract  = decrypt_mode;

    tea_round_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .key       (key),
      .ctl       (ctl[j]),
      .in_valid  (valid[j]),
      .in_ready  (ready[j]),
      .in_data   (data[j]),
      .out_valid (valid[j+1]),
      .out_ready (ready[j+1]),
      .out_data  (data[j+1])
    );
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the pipelined TEA block cipher.
module tb_top;

  localparam int unsigned TEA_ROUNDS   = 32;
  localparam int unsigned PIPE_DEPTH   = 2 * TEA_ROUNDS;
  localparam int unsigned DRAIN_LIMIT  = 20000;
  localparam int unsigned PHASES       = 7;
  localparam int unsigned PHASE_BLOCKS = 100;
  localparam logic [31:0] WORD_ZERO    = 32'h0000_0000;
  localparam logic [31:0] WORD_ONES    = 32'hFFFF_FFFF;

  typedef logic [tea_pkg::IDX_W-1:0] reg_idx_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [tea_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]                pwdata = '0;
  logic [31:0]                prdata;
  logic                       pready;

  tea_in_if  blk_if ();
  tea_out_if res_if ();

  tea_block_cipher #(.ROUNDS(TEA_ROUNDS)) u_top (
    .clk     (clk),
    .rst     (rst),
    .blk     (blk_if),
    .res     (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the register file, kept in step with every write.
  tea_pkg::tea_key_t  key_shadow = '0;
  logic               decrypt_shadow = 1'b0;
  tea_pkg::tea_data_t expected_blocks[$];
  int                 error_count = 0;
  bit                 src_idle_on = 1'b0;
  bit                 sink_idle_on = 1'b0;
  int                 sink_hold = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    blk_if.valid       = 1'b0;
    blk_if.first_word  = '0;
    blk_if.second_word = '0;
    blk_if.last_block  = 1'b0;
  end

  function automatic logic [31:0] tea_mix(logic [31:0] x, logic [31:0] sum,
                                          logic [31:0] ka, logic [31:0] kb);
    return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
  endfunction

  function automatic tea_pkg::tea_data_t tea_transform(tea_pkg::tea_data_t din,
                                                       tea_pkg::tea_key_t key,
                                                       logic decrypt);
    logic [31:0]        y;
    logic [31:0]        z;
    logic [31:0]        sum;
    tea_pkg::tea_data_t dout;
    y = din.v0;
    z = din.v1;
    if (!decrypt) begin
      sum = '0;
      for (int r = 0; r < TEA_ROUNDS; r++) begin
        sum = sum + tea_pkg::DELTA;
        y = y + tea_mix(z, sum, key.k0, key.k1);
        z = z + tea_mix(y, sum, key.k2, key.k3);
      end
    end else begin
      sum = tea_pkg::DELTA * 32'(TEA_ROUNDS);
      for (int r = 0; r < TEA_ROUNDS; r++) begin
        z = z - tea_mix(y, sum, key.k2, key.k3);
        y = y - tea_mix(z, sum, key.k0, key.k1);
        sum = sum - tea_pkg::DELTA;
      end
    end
    dout.v0 = y;
    dout.v1 = z;
    dout.last = din.last;
    return dout;
  endfunction

  // Mostly no gap, sometimes a short one, now and then a long one.
  function automatic int idle_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] pick_word();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 85) return $urandom();
    case (roll % 4)
      0: return WORD_ZERO;
      1: return WORD_ONES;
      2: return 32'h0000_0001;
      default: return 32'h8000_0000;
    endcase
  endfunction

  // Receiver: ready is changed at the falling edge only.
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        res_if.ready = 1'b0;
        sink_hold--;
      end else begin
        res_if.ready = 1'b1;
        if (sink_idle_on) sink_hold = idle_gap();
      end
    end
  end

  always @(posedge clk) begin
    tea_pkg::tea_data_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (expected_blocks.size() == 0) begin
        $error("result transfer with no block outstanding");
        error_count++;
      end else begin
        want = expected_blocks.pop_front();
        if (res_if.result_first_word !== want.v0) begin
          $error("result_first_word: expected %h, actual %h", want.v0,
                 res_if.result_first_word);
          error_count++;
        end
        if (res_if.result_second_word !== want.v1) begin
          $error("result_second_word: expected %h, actual %h", want.v1,
                 res_if.result_second_word);
          error_count++;
        end
        if (res_if.result_last !== want.last) begin
          $error("result_last: expected %b, actual %b", want.last, res_if.result_last);
          error_count++;
        end
      end
    end
  end

  // All tasks below start and end just after a falling edge.
  task automatic send_block(input logic [31:0] w0, input logic [31:0] w1, input logic lb);
    int                 gap;
    tea_pkg::tea_data_t din;
    gap = src_idle_on ? idle_gap() : 0;
    repeat (gap) @(negedge clk);
    blk_if.valid       = 1'b1;
    blk_if.first_word  = w0;
    blk_if.second_word = w1;
    blk_if.last_block  = lb;
    @(posedge clk);
    while (!blk_if.ready) @(posedge clk);
    din.v0 = w0;
    din.v1 = w1;
    din.last = lb;
    expected_blocks.push_back(tea_transform(din, key_shadow, decrypt_shadow));
    @(negedge clk);
    blk_if.valid = 1'b0;
  endtask

  task automatic wait_drained();
    int waited;
    waited = 0;
    while (expected_blocks.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (expected_blocks.size() != 0) begin
      $error("%0d blocks never came out", expected_blocks.size());
      error_count++;
      expected_blocks.delete();
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(input reg_idx_t idx, input logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      tea_pkg::REG_KEY0: key_shadow.k0 = value;
      tea_pkg::REG_KEY1: key_shadow.k1 = value;
      tea_pkg::REG_KEY2: key_shadow.k2 = value;
      tea_pkg::REG_KEY3: key_shadow.k3 = value;
      tea_pkg::REG_MODE: decrypt_shadow = value[0];
      default: ;
    endcase
  endtask

  task automatic check_register(input reg_idx_t idx);
    logic [31:0] want;
    logic [31:0] got;
    case (idx)
      tea_pkg::REG_KEY0: want = key_shadow.k0;
      tea_pkg::REG_KEY1: want = key_shadow.k1;
      tea_pkg::REG_KEY2: want = key_shadow.k2;
      tea_pkg::REG_KEY3: want = key_shadow.k3;
      default:           want = {31'b0, decrypt_shadow};
    endcase
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {idx, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if (got !== want) begin
      $error("register %0d: expected %h, actual %h", idx, want, got);
      error_count++;
    end
  endtask

  task automatic load_key(input tea_pkg::tea_key_t key, input logic decrypt);
    write_register(tea_pkg::REG_KEY0, key.k0);
    write_register(tea_pkg::REG_KEY1, key.k1);
    write_register(tea_pkg::REG_KEY2, key.k2);
    write_register(tea_pkg::REG_KEY3, key.k3);
    write_register(tea_pkg::REG_MODE, ($urandom() & ~32'h1) | {31'b0, decrypt});
  endtask

  task automatic test_reset_state();
    check_register(tea_pkg::REG_KEY0);
    check_register(tea_pkg::REG_KEY1);
    check_register(tea_pkg::REG_KEY2);
    check_register(tea_pkg::REG_KEY3);
    check_register(tea_pkg::REG_MODE);
    send_block(WORD_ZERO, WORD_ZERO, 1'b0);
    send_block(WORD_ONES, WORD_ONES, 1'b1);
    send_block($urandom(), $urandom(), 1'b0);
    wait_drained();
  endtask

  task automatic test_register_file();
    write_register(tea_pkg::REG_KEY0, 32'h0123_4567);
    write_register(tea_pkg::REG_KEY1, 32'h89AB_CDEF);
    write_register(tea_pkg::REG_KEY2, 32'hFEDC_BA98);
    write_register(tea_pkg::REG_KEY3, 32'h7654_3210);
    write_register(tea_pkg::REG_MODE, 32'h0000_0001);
    for (int i = tea_pkg::REG_KEY0; i <= tea_pkg::REG_MODE; i++)
      check_register(reg_idx_t'(i));
    // Only bit 0 of the mode register counts; the rest of a wide value is dropped.
    write_register(tea_pkg::REG_MODE, 32'hFFFF_FFFE);
    check_register(tea_pkg::REG_MODE);
    // Writes to indexes past the last register must change nothing.
    for (int i = tea_pkg::REG_MODE + 1; i < (1 << tea_pkg::IDX_W); i++)
      write_register(reg_idx_t'(i), $urandom());
    for (int i = tea_pkg::REG_KEY0; i <= tea_pkg::REG_MODE; i++)
      check_register(reg_idx_t'(i));
    send_block(32'h0BAD_F00D, 32'hC0FF_EE00, 1'b1);
    send_block(WORD_ZERO, WORD_ONES, 1'b0);
    wait_drained();
  endtask

  task automatic test_directed_blocks();
    tea_pkg::tea_key_t key;
    for (int setting = 0; setting < 4; setting++) begin
      case (setting)
        0: key = '0;
        1: key = '1;
        default: key = {$urandom(), $urandom(), $urandom(), $urandom()};
      endcase
      load_key(key, logic'(setting[0]));
      send_block(WORD_ZERO, WORD_ZERO, 1'b0);
      send_block(WORD_ONES, WORD_ONES, 1'b1);
      send_block(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
      send_block(32'h8000_0000, 32'h0000_0001, 1'b1);
      send_block($urandom(), $urandom(), logic'(setting[1]));
      // Drained here so that the next key is written with the pipe empty.
      wait_drained();
    end
  endtask

  task automatic test_random_blocks();
    tea_pkg::tea_key_t key;
    logic              decrypt;
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      if (phase == 0) key = '0;
      else if (phase == 1) key = '1;
      else key = {$urandom(), $urandom(), $urandom(), $urandom()};
      decrypt = (phase < 4) ? logic'(phase[0]) : logic'($urandom_range(0, 1));
      load_key(key, decrypt);
      // One phase with no idling at all, and one each with only one side idling.
      src_idle_on  = (phase != 2) && (phase != 6);
      sink_idle_on = (phase != 2) && (phase != 5);
      for (int n = 0; n < PHASE_BLOCKS; n++)
        send_block(pick_word(), pick_word(), logic'($urandom_range(0, 7) == 0));
    end
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    test_reset_state();
    test_register_file();
    test_directed_blocks();
    test_random_blocks();
    repeat (PIPE_DEPTH + 8) @(negedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Worst case is roughly 750 blocks, which finish far below this.
  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

// ===== sim.f =====
sv/tea_pkg.sv
sv/tea_in_if.sv
sv/tea_out_if.sv
sv/tea_cfg.sv
sv/tea_round_stage.sv
sv/tea_block_cipher.sv
test/tb_top.sv
